@@ sv/gcd_pkg.sv @@
`timescale 1ns / 1ps
package gcd_pkg;

	// field widths of the ports
	localparam int ANG_W     = 29;
	localparam int DIFF_W    = 30;
	localparam int RAD_W     = 24;
	localparam int ARC_W     = 30;
	localparam int WORD_W    = 64;

	// square root datapath: 61 result bits, 122 bit remainder
	localparam int SQ_ROOT_W = 61;
	localparam int SQ_REM_W  = 122;

	localparam int ATAN_SLOTS = 48;

	localparam logic [RAD_W-1:0] RADIUS_RESET = 24'd6371000;
	localparam logic [ARC_W-1:0] ARC_MAX      = 30'h3FFF_FFFF;
	localparam logic signed [WORD_W-1:0] Q60_ONE     = 64'sh1000_0000_0000_0000;
	localparam logic signed [WORD_W-1:0] Q60_NEG_ONE = -64'sh1000_0000_0000_0000;

	// x, y and angle of one rotation stage
	typedef struct packed {
		logic signed [WORD_W-1:0] x;
		logic signed [WORD_W-1:0] y;
		logic signed [WORD_W-1:0] z;
	} cordic_t;

	// partial remainder and root of the digit-by-digit square root
	typedef struct packed {
		logic [SQ_REM_W-1:0]  rem;
		logic [SQ_ROOT_W-1:0] root;
	} sqrt_t;

	// elaboration-time helpers for the constant tables

	// restoring division, used on constants only
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] quo;
		int k;
		rem = '0;
		quo = '0;
		for (k = 63; k >= 0; k--) begin
			rem = {rem[63:0], n[k]};
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
				quo[k] = 1'b1;
			end
		end
		return quo;
	endfunction

	// low 64 bits of (a * b) >> sh
	function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> sh;
		return p[63:0];
	endfunction

	// alternating arctangent series, d2 of zero keeps the first term only
	function automatic logic [63:0] atan_series(logic [63:0] first, logic [63:0] d2);
		logic [63:0] acc;
		logic [63:0] p;
		logic [63:0] term;
		logic [63:0] k;
		logic        done;
		acc  = '0;
		p    = first;
		k    = '0;
		done = 1'b0;
		while (p != 64'd0 && !done) begin
			term = udiv64(p, 2 * k + 64'd1);
			if (k[0])
				acc = acc - term;
			else
				acc = acc + term;
			if (d2 == 64'd0) begin
				done = 1'b1;
			end else begin
				p = udiv64(p, d2);
				k = k + 64'd1;
			end
		end
		return acc;
	endfunction

	// pi in Q62 by the Machin formula
	function automatic logic [63:0] calc_pi_q62();
		logic [63:0] a;
		logic [63:0] b;
		a = atan_series(udiv64(64'd1 << 62, 64'd5), 64'd25);
		b = atan_series(udiv64(64'd1 << 62, 64'd239), 64'd57121);
		return (a << 4) - (b << 2);
	endfunction

	localparam logic [63:0] PI_Q62         = calc_pi_q62();
	localparam logic [63:0] DEG_TO_RAD_Q64 = udiv64(PI_Q62, 64'd45);
	localparam logic signed [WORD_W-1:0] PI_Q60      = signed'(PI_Q62 >> 2);
	localparam logic signed [WORD_W-1:0] HALF_PI_Q60 = signed'(PI_Q62 >> 3);

	// atan(2^-i) in Q60
	function automatic logic [63:0] atan_q60(int i);
		logic [63:0] first;
		logic [63:0] d2;
		if (i == 0)
			return PI_Q62 >> 4;
		first = (i <= 62) ? (64'd1 << (62 - i)) : 64'd0;
		d2    = (i < 32) ? (64'd1 << (2 * i)) : 64'd0;
		return (atan_series(first, d2) + 64'd2) >> 2;
	endfunction

	// inverse gain of a rotation chain, Newton steps toward 1/sqrt(prod)
	function automatic logic [63:0] inv_gain_q60(int stages);
		logic [63:0] prod;
		logic [63:0] g;
		logic [63:0] u;
		logic [63:0] three;
		int n;
		int i;
		prod  = 64'd1 << 60;
		g     = 64'd3 << 58;
		three = 64'd3 << 60;
		n = (stages > ATAN_SLOTS) ? ATAN_SLOTS : stages;
		if (n < 0)
			n = 0;
		for (i = 0; i < n; i++) begin
			if (2 * i < 64)
				prod = prod + (prod >> (2 * i));
		end
		for (i = 0; i < 10; i++) begin
			u = mul_shr(prod, mul_shr(g, g, 60), 60);
			if (u >= three)
				g = g >> 1;
			else
				g = mul_shr(g, three - u, 61);
		end
		return g;
	endfunction

endpackage

@@ sv/gcd_deg2rad.sv @@
`timescale 1ns / 1ps
module gcd_deg2rad #(
	parameter int AFB = 20
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [gcd_pkg::DIFF_W-1:0]     ang,
	output logic signed [gcd_pkg::WORD_W-1:0]     th
);

	localparam logic [63:0] FULL  = 64'd360 << AFB;
	localparam logic [63:0] HALF  = 64'd180 << AFB;
	localparam logic [63:0] SPAN  = 64'd1 << (gcd_pkg::DIFF_W - 1);
	localparam bit          WRAP  = HALF < SPAN;
	localparam logic [63:0] RMAX  = WRAP ? HALF : SPAN;
	localparam int          MAGW  = $clog2(RMAX + 64'd1);
	localparam logic [31:0] C_LO  = gcd_pkg::DEG_TO_RAD_Q64[31:0];
	localparam logic [31:0] C_HI  = gcd_pkg::DEG_TO_RAD_Q64[63:32];

	logic [MAGW-1:0] mag_s3;
	logic            neg_s3;

	generate
		if (WRAP) begin : g_wrap
			// (ang + half) mod full by reciprocal multiply, offset keeps it positive
			localparam logic [63:0] K    = (SPAN + FULL - 64'd1) / FULL;
			localparam logic [63:0] OFF  = K * FULL + HALF;
			localparam logic [63:0] UMAX = SPAN - 64'd1 + OFF;
			localparam int          UW   = $clog2(UMAX + 64'd1);
			localparam int          L    = $clog2(FULL);
			localparam int          S    = UW + L;
			localparam logic [63:0] M    = ((64'd1 << S) + FULL - 64'd1) / FULL;
			localparam int          MW   = $clog2(M + 64'd1);
			localparam int          QW   = $clog2(UMAX / FULL + 64'd1);
			localparam logic [UW-1:0] FULL_U = FULL[UW-1:0];
			localparam logic [L:0]    HALF_L = HALF[L:0];

			logic [UW-1:0]    u_s1;
			logic [UW-1:0]    u_s2;
			logic [UW+MW-1:0] prod_s2;
			logic [63:0]      u_c;
			logic [QW-1:0]    q_c;
			logic [UW-1:0]    rmod_c;
			logic [L:0]       r_c;

			assign u_c    = 64'(ang) + OFF;
			assign q_c    = prod_s2[S +: QW];
			assign rmod_c = u_s2 - UW'(q_c) * FULL_U;
			assign r_c    = {1'b0, rmod_c[L-1:0]} - HALF_L;

			always_ff @(posedge clk) begin
				if (en) begin
					u_s1    <= u_c[UW-1:0];
					u_s2    <= u_s1;
					prod_s2 <= (UW+MW)'(u_s1) * (UW+MW)'(M[MW-1:0]);
					neg_s3  <= r_c[L];
					mag_s3  <= MAGW'(r_c[L] ? -r_c : r_c);
				end
			end
		end else begin : g_pass
			// angle already within half a turn
			logic signed [gcd_pkg::DIFF_W-1:0] d_s1;
			logic signed [gcd_pkg::DIFF_W-1:0] d_s2;

			always_ff @(posedge clk) begin
				if (en) begin
					d_s1   <= ang;
					d_s2   <= d_s1;
					neg_s3 <= d_s2[gcd_pkg::DIFF_W-1];
					mag_s3 <= MAGW'(d_s2[gcd_pkg::DIFF_W-1] ? -d_s2 : d_s2);
				end
			end
		end
	endgenerate

	// degrees to radians, constant split in two 32 bit halves
	logic [MAGW+31:0] plo_s4;
	logic [MAGW+31:0] phi_s4;
	logic             neg_s4;
	logic [127:0]     full_c;
	logic [63:0]      m_c;
	logic signed [gcd_pkg::WORD_W-1:0] th_s5;

	assign full_c = (128'(phi_s4) << 32) + 128'(plo_s4);
	assign m_c    = full_c[AFB+4 +: 64];

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s4 <= (MAGW+32)'(mag_s3) * (MAGW+32)'(C_LO);
			phi_s4 <= (MAGW+32)'(mag_s3) * (MAGW+32)'(C_HI);
			neg_s4 <= neg_s3;
			th_s5  <= neg_s4 ? -signed'(m_c) : signed'(m_c);
		end
	end

	assign th = th_s5;

endmodule

@@ sv/gcd_cordic_cell.sv @@
`timescale 1ns / 1ps
module gcd_cordic_cell #(
	parameter int STAGE  = 0,
	parameter bit VECTOR = 1'b0
) (
	input  logic             clk,
	input  logic             en,
	input  gcd_pkg::cordic_t din,
	output gcd_pkg::cordic_t dout
);

	localparam logic signed [gcd_pkg::WORD_W-1:0] ATAN = signed'(gcd_pkg::atan_q60(STAGE));

	logic signed [gcd_pkg::WORD_W-1:0] x;
	logic signed [gcd_pkg::WORD_W-1:0] y;
	logic signed [gcd_pkg::WORD_W-1:0] xs;
	logic signed [gcd_pkg::WORD_W-1:0] ys;
	logic                              cw;
	gcd_pkg::cordic_t                  nxt;
	gcd_pkg::cordic_t                  data_s1;

	// rotation steers on the angle, vectoring on the sign of y
	always_comb begin
		x  = din.x;
		y  = din.y;
		xs = x >>> STAGE;
		ys = y >>> STAGE;
		cw = VECTOR ? !y[gcd_pkg::WORD_W-1] : din.z[gcd_pkg::WORD_W-1];
		if (cw) begin
			nxt.x = x + ys;
			nxt.y = y - xs;
			nxt.z = din.z + ATAN;
		end else begin
			nxt.x = x - ys;
			nxt.y = y + xs;
			nxt.z = din.z - ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s1 <= nxt;
	end

	assign dout = data_s1;

endmodule

@@ sv/gcd_sqrt_cell.sv @@
`timescale 1ns / 1ps
module gcd_sqrt_cell #(
	parameter int B = 60
) (
	input  logic           clk,
	input  logic           en,
	input  gcd_pkg::sqrt_t din,
	output gcd_pkg::sqrt_t dout
);

	logic [gcd_pkg::SQ_REM_W-1:0] trial;
	logic                         ge;
	gcd_pkg::sqrt_t               nxt;
	gcd_pkg::sqrt_t               data_s1;

	// try result bit B: need rem >= 2*root*2^B + 2^(2B)
	always_comb begin
		trial = (gcd_pkg::SQ_REM_W'(din.root) << (B + 1))
			| (gcd_pkg::SQ_REM_W'(1) << (2 * B));
		ge = din.rem >= trial;
		nxt.rem  = ge ? din.rem - trial : din.rem;
		nxt.root = din.root | (gcd_pkg::SQ_ROOT_W'(ge) << B);
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s1 <= nxt;
	end

	assign dout = data_s1;

endmodule

@@ sv/gcd_mul60.sv @@
`timescale 1ns / 1ps
module gcd_mul60 (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [gcd_pkg::WORD_W-1:0] a,
	input  logic signed [gcd_pkg::WORD_W-1:0] b,
	output logic signed [gcd_pkg::WORD_W-1:0] p
);

	logic [63:0]  ma_s1;
	logic [63:0]  mb_s1;
	logic         neg_s1;
	logic [63:0]  pp00_s2;
	logic [63:0]  pp01_s2;
	logic [63:0]  pp10_s2;
	logic [63:0]  pp11_s2;
	logic         neg_s2;
	logic [127:0] sum_c;
	logic [63:0]  m_c;
	logic signed [gcd_pkg::WORD_W-1:0] p_s3;

	// magnitude product in four 32x32 pieces, truncated to Q60
	assign sum_c = {pp11_s2, 64'd0} + {32'd0, pp01_s2, 32'd0}
		+ {32'd0, pp10_s2, 32'd0} + {64'd0, pp00_s2};
	assign m_c = sum_c[123:60];

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1   <= a[63] ? 64'(-a) : 64'(a);
			mb_s1   <= b[63] ? 64'(-b) : 64'(b);
			neg_s1  <= a[63] ^ b[63];
			pp00_s2 <= 64'(ma_s1[31:0])  * 64'(mb_s1[31:0]);
			pp01_s2 <= 64'(ma_s1[31:0])  * 64'(mb_s1[63:32]);
			pp10_s2 <= 64'(ma_s1[63:32]) * 64'(mb_s1[31:0]);
			pp11_s2 <= 64'(ma_s1[63:32]) * 64'(mb_s1[63:32]);
			neg_s2  <= neg_s1;
			p_s3    <= neg_s2 ? -signed'(m_c) : signed'(m_c);
		end
	end

	assign p = p_s3;

endmodule

@@ sv/great_circle_distance.sv @@
`timescale 1ns / 1ps
// Great circle distance by the spherical law of cosines. Each transfer on the point
// channel carries two positions (latitude, longitude in degrees with ANGLE_FRAC_BITS
// fraction bits, any angle reduced modulo a full turn) and yields one arc_length in
// 1/16 metre on a sphere of radius cfg radius (metres, resets to 6371000), saturated
// at the field maximum. The datapath is fully unrolled: three rotation chains for the
// sines and cosines, Q60 multipliers, two 61-cell square root chains and a vectoring
// chain for the arc cosine. One item is accepted every cycle while the input is not
// stalled. The input is stalled only while the last pipeline stage holds a result
// and the output register is waiting to be taken. Write the radius only while no
// item is in flight.
module great_circle_distance #(
	parameter int ANGLE_FRAC_BITS = 20,
	parameter int CORDIC_STAGES   = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [gcd_pkg::RAD_W-1:0]           cfg_wr_data,
	input  logic                                point_valid,
	output logic                                point_stall,
	input  logic signed [gcd_pkg::ANG_W-1:0]    lat_first,
	input  logic signed [gcd_pkg::ANG_W-1:0]    lon_first,
	input  logic signed [gcd_pkg::ANG_W-1:0]    lat_second,
	input  logic signed [gcd_pkg::ANG_W-1:0]    lon_second,
	output logic                                arc_valid,
	input  logic                                arc_stall,
	output logic [gcd_pkg::ARC_W-1:0]           arc_length
);

	localparam int N   = CORDIC_STAGES;
	localparam int LAT = 2 * N + 79;
	localparam logic signed [gcd_pkg::WORD_W-1:0] INV_GAIN =
		signed'(gcd_pkg::inv_gain_q60(CORDIC_STAGES));

	logic                        en;
	logic [LAT-1:0]              vld_q;
	logic [gcd_pkg::RAD_W-1:0]   radius_q;
	logic                        arc_valid_q;
	logic [gcd_pkg::ARC_W-1:0]   arc_length_q;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radius_q <= gcd_pkg::RADIUS_RESET;
		else if (cfg_wr_en)
			radius_q <= cfg_wr_data;
	end

	// pipeline moves unless a finished result is blocked at the end
	assign en          = !(vld_q[LAT-1] && arc_valid_q && arc_stall);
	assign point_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], point_valid};
	end

	// angle reduction and conversion for both latitudes and the longitude difference
	logic signed [gcd_pkg::DIFF_W-1:0] ang_c [3];
	logic signed [gcd_pkg::WORD_W-1:0] th_c  [3];

	assign ang_c[0] = {lat_first[gcd_pkg::ANG_W-1], lat_first};
	assign ang_c[1] = {lat_second[gcd_pkg::ANG_W-1], lat_second};
	assign ang_c[2] = {lon_first[gcd_pkg::ANG_W-1], lon_first}
		- {lon_second[gcd_pkg::ANG_W-1], lon_second};

	genvar t, k;
	generate
		for (t = 0; t < 3; t++) begin : g_ang
			gcd_deg2rad #(.AFB(ANGLE_FRAC_BITS)) u_d2r (
				.clk (clk),
				.en  (en),
				.ang (ang_c[t]),
				.th  (th_c[t])
			);
		end
	endgenerate

	// fold into [-pi/2, pi/2], flip the results later
	gcd_pkg::cordic_t fold_c [3];
	logic [2:0]       flip_c;
	gcd_pkg::cordic_t fold_s [3];
	logic [2:0]       flip_q [N+1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fold_c[i].x = INV_GAIN;
			fold_c[i].y = '0;
			flip_c[i]   = 1'b1;
			if (th_c[i] > gcd_pkg::HALF_PI_Q60)
				fold_c[i].z = th_c[i] - gcd_pkg::PI_Q60;
			else if (th_c[i] < -gcd_pkg::HALF_PI_Q60)
				fold_c[i].z = th_c[i] + gcd_pkg::PI_Q60;
			else begin
				fold_c[i].z = th_c[i];
				flip_c[i]   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_s    <= fold_c;
			flip_q[0] <= flip_c;
			for (int i = 0; i < N; i++)
				flip_q[i+1] <= flip_q[i];
		end
	end

	// rotation chains
	gcd_pkg::cordic_t rot_c [3][N];

	generate
		for (t = 0; t < 3; t++) begin : g_rot
			for (k = 0; k < N; k++) begin : g_cell
				if (k == 0) begin : g_first
					gcd_cordic_cell #(.STAGE(k), .VECTOR(1'b0)) u_cell (
						.clk  (clk),
						.en   (en),
						.din  (fold_s[t]),
						.dout (rot_c[t][k])
					);
				end else begin : g_next
					gcd_cordic_cell #(.STAGE(k), .VECTOR(1'b0)) u_cell (
						.clk  (clk),
						.en   (en),
						.din  (rot_c[t][k-1]),
						.dout (rot_c[t][k])
					);
				end
			end
		end
	endgenerate

	// undo the fold
	logic signed [gcd_pkg::WORD_W-1:0] cos_s [3];
	logic signed [gcd_pkg::WORD_W-1:0] sin_s [2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				cos_s[i] <= flip_q[N][i] ? -rot_c[i][N-1].x : rot_c[i][N-1].x;
			for (int i = 0; i < 2; i++)
				sin_s[i] <= flip_q[N][i] ? -rot_c[i][N-1].y : rot_c[i][N-1].y;
		end
	end

	// s = cos a cos b cos d + sin a sin b
	logic signed [gcd_pkg::WORD_W-1:0] cc_c;
	logic signed [gcd_pkg::WORD_W-1:0] ss_c;
	logic signed [gcd_pkg::WORD_W-1:0] ccc_c;
	logic signed [gcd_pkg::WORD_W-1:0] cd_q [3];
	logic signed [gcd_pkg::WORD_W-1:0] ss_q [3];

	gcd_mul60 u_mul_cc (.clk(clk), .en(en), .a(cos_s[0]), .b(cos_s[1]), .p(cc_c));
	gcd_mul60 u_mul_ss (.clk(clk), .en(en), .a(sin_s[0]), .b(sin_s[1]), .p(ss_c));
	gcd_mul60 u_mul_cd (.clk(clk), .en(en), .a(cc_c), .b(cd_q[2]), .p(ccc_c));

	always_ff @(posedge clk) begin
		if (en) begin
			cd_q[0] <= cos_s[2];
			cd_q[1] <= cd_q[0];
			cd_q[2] <= cd_q[1];
			ss_q[0] <= ss_c;
			ss_q[1] <= ss_q[0];
			ss_q[2] <= ss_q[1];
		end
	end

	// sum and clamp to [-1, 1]
	logic signed [gcd_pkg::WORD_W-1:0] sum_c;
	logic signed [gcd_pkg::WORD_W-1:0] s_s;

	assign sum_c = ccc_c + ss_q[2];

	always_ff @(posedge clk) begin
		if (en) begin
			if (sum_c > gcd_pkg::Q60_ONE)
				s_s <= gcd_pkg::Q60_ONE;
			else if (sum_c < gcd_pkg::Q60_NEG_ONE)
				s_s <= gcd_pkg::Q60_NEG_ONE;
			else
				s_s <= sum_c;
		end
	end

	// square root operands (1 - s)/2 and (1 + s)/2, scaled by 2^60
	logic [63:0]    qy_c;
	logic [63:0]    qx_c;
	gcd_pkg::sqrt_t sqp_s [2];

	assign qy_c = 64'(gcd_pkg::Q60_ONE - s_s) >> 1;
	assign qx_c = 64'(gcd_pkg::Q60_ONE + s_s) >> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			sqp_s[0].rem  <= gcd_pkg::SQ_REM_W'({qy_c[gcd_pkg::SQ_ROOT_W-1:0], 60'd0});
			sqp_s[0].root <= '0;
			sqp_s[1].rem  <= gcd_pkg::SQ_REM_W'({qx_c[gcd_pkg::SQ_ROOT_W-1:0], 60'd0});
			sqp_s[1].root <= '0;
		end
	end

	// square root chains, one result bit per cell
	gcd_pkg::sqrt_t sq_c [2][gcd_pkg::SQ_ROOT_W];

	generate
		for (t = 0; t < 2; t++) begin : g_sq
			for (k = 0; k < gcd_pkg::SQ_ROOT_W; k++) begin : g_cell
				if (k == 0) begin : g_first
					gcd_sqrt_cell #(.B(gcd_pkg::SQ_ROOT_W - 1 - k)) u_cell (
						.clk  (clk),
						.en   (en),
						.din  (sqp_s[t]),
						.dout (sq_c[t][k])
					);
				end else begin : g_next
					gcd_sqrt_cell #(.B(gcd_pkg::SQ_ROOT_W - 1 - k)) u_cell (
						.clk  (clk),
						.en   (en),
						.din  (sq_c[t][k-1]),
						.dout (sq_c[t][k])
					);
				end
			end
		end
	endgenerate

	// vectoring chain: angle of (x, y) gives half the arc
	gcd_pkg::cordic_t vin_c;
	gcd_pkg::cordic_t vec_c [N];

	assign vin_c.x = signed'(64'(sq_c[1][gcd_pkg::SQ_ROOT_W-1].root));
	assign vin_c.y = signed'(64'(sq_c[0][gcd_pkg::SQ_ROOT_W-1].root));
	assign vin_c.z = '0;

	generate
		for (k = 0; k < N; k++) begin : g_vec
			if (k == 0) begin : g_first
				gcd_cordic_cell #(.STAGE(k), .VECTOR(1'b1)) u_cell (
					.clk  (clk),
					.en   (en),
					.din  (vin_c),
					.dout (vec_c[k])
				);
			end else begin : g_next
				gcd_cordic_cell #(.STAGE(k), .VECTOR(1'b1)) u_cell (
					.clk  (clk),
					.en   (en),
					.din  (vec_c[k-1]),
					.dout (vec_c[k])
				);
			end
		end
	endgenerate

	// arc times radius, shifted down to 1/16 metre and saturated
	logic signed [gcd_pkg::WORD_W-1:0] a2_c;
	logic [63:0]                       alpha_s;
	logic [55:0]                       plo_s;
	logic [55:0]                       phi_s;
	logic [95:0]                       prod_c;
	logic [gcd_pkg::ARC_W-1:0]         dist_s;

	assign a2_c   = vec_c[N-1].z <<< 1;
	assign prod_c = (96'(phi_s) << 32) + 96'(plo_s);

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s <= a2_c[gcd_pkg::WORD_W-1] ? 64'd0 : 64'(a2_c);
			plo_s   <= 56'(alpha_s[31:0])  * 56'(radius_q);
			phi_s   <= 56'(alpha_s[63:32]) * 56'(radius_q);
			dist_s  <= (|prod_c[95:86]) ? gcd_pkg::ARC_MAX : prod_c[85:56];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			arc_valid_q <= 1'b0;
		else if (!arc_valid_q || !arc_stall)
			arc_valid_q <= vld_q[LAT-1];
	end

	always_ff @(posedge clk) begin
		if (!arc_valid_q || !arc_stall)
			arc_length_q <= dist_s;
	end

	assign arc_valid  = arc_valid_q;
	assign arc_length = arc_length_q;

	// a transfer enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && !point_stall) |=> vld_q[0])
		else $error("accepted point did not enter the pipeline");

	// a blocked result stays at the end of the pipeline
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[LAT-1] && arc_valid && arc_stall) |=> vld_q[LAT-1])
		else $error("blocked result left the last stage");

	// a result only appears when the last stage held one
	a_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arc_valid) |-> $past(vld_q[LAT-1]))
		else $error("result shown without a finished item");

endmodule
